@@ rtl/core/tagged_audio_chunk_deframer_assert.svh @@
// Assertion macros shared by the checker of the tagged audio chunk deframer.
// No dependencies; included by the checker file.
`ifndef TAGGED_AUDIO_CHUNK_DEFRAMER_ASSERT_SVH
`define TAGGED_AUDIO_CHUNK_DEFRAMER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define TACD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tacd assertion failed");

// Antecedent implies consequent in the next cycle.
`define TACD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tacd assertion failed");

`endif

@@ rtl/core/tacd_pkg.sv @@
// Shared types and constants of the tagged audio chunk deframer.
// No dependencies; imported by every module of the block but tacd_fifo.
package tacd_pkg;

	localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
	localparam logic [2:0] KIND_HDR_OK   = 3'd1;
	localparam logic [2:0] KIND_HDR_REJ  = 3'd2;
	localparam logic [2:0] KIND_FINISHED = 3'd3;
	localparam logic [2:0] KIND_ERROR    = 3'd4;

	localparam logic [31:0] TAG_START = 32'h5343486C;
	localparam logic [31:0] TAG_PT    = 32'h50540000;
	localparam logic [31:0] TAG_DATA  = 32'h5343446C;
	localparam logic [31:0] TAG_END   = 32'h5343456C;

	localparam logic [7:0] ETAG_SUB      = 8'hFD;
	localparam logic [7:0] ETAG_CHANNELS = 8'h82;
	localparam logic [7:0] ETAG_CODEC    = 8'h83;
	localparam logic [7:0] ETAG_SAMPLES  = 8'h85;
	localparam logic [7:0] ETAG_SUB_END  = 8'h8A;
	localparam logic [7:0] ETAG_END      = 8'hFF;

	localparam logic [31:0] CHANNELS_OK = 32'd2;
	localparam logic [31:0] CODEC_OK    = 32'd7;

	localparam logic [16:0] SEG_MIN       = 17'd4;
	localparam logic [16:0] SEG_MAX       = 17'd65536;
	localparam logic [16:0] SEG_RESET     = 17'd4096;

	localparam logic [31:0] RATE_HZ = 32'd22050;
	localparam logic [34:0] PTS_HZ  = 35'd90000;

	// floor(n/22050) = floor((n>>1) * RECIP_S >> 45), exact for 31-bit (n>>1).
	localparam logic [63:0] RECIP_S_W = ((64'd1 << 45) + 64'd11024) / 64'd11025;
	localparam logic [31:0] RECIP_S   = RECIP_S_W[31:0];
	// floor(t/49) = floor(t * RECIP_T >> 29), exact for 23-bit t.
	localparam logic [63:0] RECIP_T_W = ((64'd1 << 29) + 64'd48) / 64'd49;
	localparam logic [23:0] RECIP_T   = RECIP_T_W[23:0];

	localparam int MID_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 8;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data;
		logic        seg_first;
		logic        seg_last;
		logic        frm_begin;
		logic        frm_finish;
		logic [31:0] offset;
		logic [31:0] num;
	} mid_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  payload_byte;
		logic        segment_first;
		logic        segment_last;
		logic        frame_begin;
		logic        frame_finish;
		logic [34:0] presentation_time;
		logic [17:0] time_seconds;
		logic [31:0] segment_offset;
		logic [17:0] length_seconds;
	} out_item_t;

endpackage

@@ rtl/core/tacd_fifo.sv @@
// Small register-based queue used between the stages of the deframer.
// Depends on nothing; DEPTH must be a power of two.
module tacd_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [W-1:0]               wr_data,
	output logic                       full,
	input  logic                       rd_en,
	output logic [W-1:0]               rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

@@ rtl/core/tacd_front.sv @@
// Front part of the deframer: parses the container one byte per transaction
// and classifies each byte into at most one pending result. Uses tacd_pkg.
module tacd_front
	import tacd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_data,
	input  logic        in_go,
	input  logic [7:0]  in_byte,
	input  logic        in_eoi,
	output logic        emit,
	output mid_item_t   item
);
	typedef enum logic [14:0] {
		PH_START = 15'h0001,
		PH_HSIZE = 15'h0002,
		PH_PT    = 15'h0004,
		PH_HTAG  = 15'h0008,
		PH_HLEN  = 15'h0010,
		PH_HVAL  = 15'h0020,
		PH_STAG  = 15'h0040,
		PH_SLEN  = 15'h0080,
		PH_SVAL  = 15'h0100,
		PH_HSKIP = 15'h0200,
		PH_CID   = 15'h0400,
		PH_CSIZE = 15'h0800,
		PH_DATA  = 15'h1000,
		PH_CSKIP = 15'h2000,
		PH_DONE  = 15'h4000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [16:0] max_seg_q;
	logic [31:0] pos_q, pos_n, limit_q, limit_n, wa_q, wa_n;
	logic [7:0]  ebl_q, ebl_n, etag_q, etag_n;
	logic [31:0] chan_q, chan_n, codec_q, codec_n, total_q, total_n;
	logic [31:0] ctag_q, ctag_n, cbl_q, cbl_n, sc_q, sc_n, fw_q, fw_n;
	logic [31:0] segoff_q, segoff_n;
	logic [16:0] sbl_q, sbl_n;
	logic        first_q, first_n;
	logic [2:0]  tick_q, tick_n;

	logic [31:0] pos_inc, wa_shl, wa_shr, cbl_dec, fw_or, offset;
	logic [16:0] cap, sbl0, sbl_dec;
	logic        in_header, seg_new, elem_done, elem_sub;
	logic [31:0] elem_val;

	assign in_header = |phase_q[9:0];
	assign pos_inc   = pos_q + 32'd1;
	assign wa_shl    = {wa_q[23:0], in_byte};
	assign wa_shr    = {in_byte, wa_q[31:8]};
	assign cap       = (max_seg_q < SEG_MIN) ? SEG_MIN :
		(max_seg_q > SEG_MAX) ? SEG_MAX : max_seg_q;
	assign seg_new   = (sbl_q == '0);
	assign sbl0      = !seg_new ? sbl_q :
		((cbl_q < {15'd0, cap}) ? cbl_q[16:0] : cap);
	assign sbl_dec   = sbl0 - 17'd1;
	assign cbl_dec   = cbl_q - 32'd1;
	assign offset    = seg_new ? pos_q : segoff_q;

	always_comb begin
		case (tick_q[1:0])
			2'd0: fw_or = fw_q | {24'd0, in_byte};
			2'd1: fw_or = fw_q | {16'd0, in_byte, 8'd0};
			2'd2: fw_or = fw_q | {8'd0, in_byte, 16'd0};
			default: fw_or = fw_q | {in_byte, 24'd0};
		endcase
	end

	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		limit_n  = limit_q;
		wa_n     = wa_q;
		ebl_n    = ebl_q;
		etag_n   = etag_q;
		chan_n   = chan_q;
		codec_n  = codec_q;
		total_n  = total_q;
		ctag_n   = ctag_q;
		cbl_n    = cbl_q;
		sc_n     = sc_q;
		fw_n     = fw_q;
		segoff_n = segoff_q;
		sbl_n    = sbl_q;
		first_n  = first_q;
		tick_n   = tick_q;
		emit     = 1'b0;
		item     = '0;
		elem_done = 1'b0;
		elem_sub  = 1'b0;
		elem_val  = '0;
		if (in_go && phase_q != PH_DONE) begin
			if (in_eoi) begin
				emit      = 1'b1;
				item.kind = in_header ? KIND_HDR_REJ : KIND_ERROR;
				phase_n   = PH_DONE;
			end else begin
				pos_n = pos_inc;
				case (phase_q)
					PH_START, PH_PT, PH_CID: begin
						wa_n = wa_shl;
						if (tick_q == 3'd3) begin
							tick_n = '0;
							if (phase_q == PH_CID) begin
								ctag_n  = wa_shl;
								phase_n = PH_CSIZE;
							end else if (wa_shl != ((phase_q == PH_START) ? TAG_START : TAG_PT)) begin
								emit      = 1'b1;
								item.kind = KIND_HDR_REJ;
								phase_n   = PH_DONE;
							end else begin
								phase_n = (phase_q == PH_START) ? PH_HSIZE : PH_HTAG;
							end
						end else begin
							tick_n = tick_q + 3'd1;
						end
					end
					PH_HSIZE, PH_CSIZE: begin
						wa_n = wa_shr;
						if (tick_q == 3'd3) begin
							tick_n = '0;
							if (phase_q == PH_HSIZE) begin
								limit_n = wa_shr;
								phase_n = PH_PT;
							end else if (wa_shr < 32'd8) begin
								emit      = 1'b1;
								item.kind = KIND_ERROR;
								phase_n   = PH_DONE;
							end else begin
								cbl_n = wa_shr - 32'd8;
								if (ctag_q == TAG_END) begin
									emit      = 1'b1;
									item.kind = KIND_FINISHED;
									phase_n   = PH_DONE;
								end else if (ctag_q == TAG_DATA) begin
									first_n = 1'b1;
									fw_n    = '0;
									sbl_n   = '0;
									phase_n = (wa_shr != 32'd8) ? PH_DATA : PH_CID;
								end else begin
									phase_n = (wa_shr != 32'd8) ? PH_CSKIP : PH_CID;
								end
							end
						end else begin
							tick_n = tick_q + 3'd1;
						end
					end
					PH_HTAG: begin
						etag_n = in_byte;
						if (in_byte == ETAG_SUB) begin
							phase_n = PH_STAG;
						end else if (in_byte == ETAG_END) begin
							if (chan_q != CHANNELS_OK || codec_q != CODEC_OK ||
									pos_inc > limit_q) begin
								emit      = 1'b1;
								item.kind = KIND_HDR_REJ;
								phase_n   = PH_DONE;
							end else if (pos_inc == limit_q) begin
								emit      = 1'b1;
								item.kind = KIND_HDR_OK;
								item.num  = total_q;
								phase_n   = PH_CID;
								tick_n    = '0;
							end else begin
								phase_n = PH_HSKIP;
							end
						end else begin
							phase_n = PH_HLEN;
						end
					end
					PH_STAG: begin
						etag_n  = in_byte;
						phase_n = PH_SLEN;
					end
					PH_HLEN, PH_SLEN: begin
						wa_n  = '0;
						ebl_n = in_byte;
						if (in_byte == 8'd0) begin
							elem_done = 1'b1;
							elem_sub  = (phase_q == PH_SLEN);
						end else begin
							phase_n = (phase_q == PH_SLEN) ? PH_SVAL : PH_HVAL;
						end
					end
					PH_HVAL, PH_SVAL: begin
						wa_n  = wa_shl;
						ebl_n = ebl_q - 8'd1;
						if (ebl_q == 8'd1) begin
							elem_done = 1'b1;
							elem_sub  = (phase_q == PH_SVAL);
							elem_val  = wa_shl;
						end
					end
					PH_HSKIP: begin
						if (pos_inc == limit_q) begin
							emit      = 1'b1;
							item.kind = KIND_HDR_OK;
							item.num  = total_q;
							phase_n   = PH_CID;
							tick_n    = '0;
						end
					end
					PH_CSKIP: begin
						cbl_n = cbl_dec;
						if (cbl_dec == '0) begin
							phase_n = PH_CID;
							tick_n  = '0;
						end
					end
					PH_DATA: begin
						emit            = 1'b1;
						item.kind       = KIND_PAYLOAD;
						item.data       = in_byte;
						item.seg_first  = seg_new;
						item.seg_last   = (sbl0 == 17'd1);
						item.frm_begin  = first_q;
						item.frm_finish = (cbl_q == {15'd0, sbl0});
						item.offset     = offset;
						item.num        = sc_q;
						segoff_n        = offset;
						if (first_q && tick_q < 3'd4) begin
							fw_n   = fw_or;
							tick_n = tick_q + 3'd1;
						end
						// The frame word counts toward the sample total once the
						// first segment of the chunk is complete.
						if (sbl_dec == '0 && first_q) begin
							sc_n    = sc_q + ((tick_q < 3'd4) ? fw_or : fw_q);
							first_n = 1'b0;
						end
						cbl_n = cbl_dec;
						sbl_n = sbl_dec;
						if (cbl_dec == '0) begin
							sbl_n   = '0;
							phase_n = PH_CID;
							tick_n  = '0;
						end
					end
					default: begin
						phase_n = PH_DONE;
					end
				endcase
				if (elem_done) begin
					if (elem_sub) begin
						if (etag_q == ETAG_CHANNELS) begin
							chan_n = elem_val;
						end else if (etag_q == ETAG_CODEC) begin
							codec_n = elem_val;
						end else if (etag_q == ETAG_SAMPLES) begin
							total_n = elem_val;
						end
						phase_n = (etag_q == ETAG_SUB_END) ? PH_HTAG : PH_STAG;
					end else begin
						phase_n = PH_HTAG;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			max_seg_q <= SEG_RESET;
			pos_q     <= '0;
			limit_q   <= '0;
			wa_q      <= '0;
			ebl_q     <= '0;
			etag_q    <= '0;
			chan_q    <= '0;
			codec_q   <= '0;
			total_q   <= '0;
			ctag_q    <= '0;
			cbl_q     <= '0;
			sc_q      <= '0;
			fw_q      <= '0;
			segoff_q  <= '0;
			sbl_q     <= '0;
			first_q   <= 1'b1;
			tick_q    <= '0;
		end else begin
			if (cfg_we) begin
				max_seg_q <= cfg_data;
			end
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			limit_q  <= limit_n;
			wa_q     <= wa_n;
			ebl_q    <= ebl_n;
			etag_q   <= etag_n;
			chan_q   <= chan_n;
			codec_q  <= codec_n;
			total_q  <= total_n;
			ctag_q   <= ctag_n;
			cbl_q    <= cbl_n;
			sc_q     <= sc_n;
			fw_q     <= fw_n;
			segoff_q <= segoff_n;
			sbl_q    <= sbl_n;
			first_q  <= first_n;
			tick_q   <= tick_n;
		end
	end
endmodule

@@ rtl/core/tacd_back.sv @@
// Back part of the deframer: turns pending results into output transactions,
// computing the time fields in a three-stage pipeline. Uses tacd_pkg, tacd_fifo.
module tacd_back
	import tacd_pkg::*;
#(
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  mid_item_t mid_item,
	input  logic      mid_empty,
	output logic      mid_pop,
	input  logic      pop,
	output logic      empty,
	output out_item_t out_item
);
	localparam int CW = $clog2(OUT_DEPTH + 1);

	mid_item_t   item_s1, item_s2, item_s3;
	logic        v_s1, v_s2, v_s3;
	logic [62:0] p1_s1;
	logic [17:0] q_s2, q_s3;
	logic [14:0] r_s2;
	logic [46:0] p2_s3;
	logic [34:0] qa_s3;
	logic [34:0] seg_pts_q, pts;
	logic [17:0] seg_sec_q;
	logic [17:0] q_c;
	logic [31:0] rem_c;
	logic [CW-1:0] out_count;
	logic [CW:0]   used;
	out_item_t     res;

	assign used    = {1'b0, out_count} + (CW+1)'(v_s1) + (CW+1)'(v_s2) + (CW+1)'(v_s3);
	// Only issue when the output queue is sure to have room at the end of the pipe.
	assign mid_pop = !mid_empty && (used < (CW+1)'(OUT_DEPTH));

	assign q_c   = p1_s1[62:45];
	assign rem_c = item_s1.num - (32'(q_c) * RATE_HZ);
	assign pts   = qa_s3 + {18'd0, p2_s3[45:29]};

	always_ff @(posedge clk) begin
		item_s1 <= mid_item;
		p1_s1   <= 63'(mid_item.num[31:1]) * 63'(RECIP_S);
		item_s2 <= item_s1;
		q_s2    <= q_c;
		r_s2    <= rem_c[14:0];
		item_s3 <= item_s2;
		q_s3    <= q_s2;
		p2_s3   <= 47'(r_s2 * 23'd200) * 47'(RECIP_T);
		qa_s3   <= 35'(q_s2) * PTS_HZ;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			seg_pts_q <= '0;
			seg_sec_q <= '0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3 && item_s3.kind == KIND_PAYLOAD && item_s3.seg_first) begin
				seg_pts_q <= pts;
				seg_sec_q <= q_s3;
			end
		end
	end

	always_comb begin
		res      = '0;
		res.kind = item_s3.kind;
		if (item_s3.kind == KIND_PAYLOAD) begin
			res.payload_byte      = item_s3.data;
			res.segment_first     = item_s3.seg_first;
			res.segment_last      = item_s3.seg_last;
			res.frame_begin       = item_s3.frm_begin;
			res.frame_finish      = item_s3.frm_finish;
			res.presentation_time = item_s3.seg_first ? pts : seg_pts_q;
			res.time_seconds      = item_s3.seg_first ? q_s3 : seg_sec_q;
			res.segment_offset    = item_s3.offset;
		end else if (item_s3.kind == KIND_HDR_OK) begin
			res.length_seconds = q_s3;
		end
	end

	// The issue rule above keeps this queue from overflowing.
	tacd_fifo #(
		.W($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(v_s3),
		.wr_data(res),
		.full(),
		.rd_en(pop),
		.rd_data(out_item),
		.empty(empty),
		.count(out_count)
	);
endmodule

@@ rtl/core/tagged_audio_chunk_deframer.sv @@
// Top level of the tagged audio chunk deframer: front parser, pending-result
// queue and back pipeline. Uses tacd_pkg, tacd_front, tacd_fifo, tacd_back.
//
//   channel   handshake        payload
//   input     push / full      data_byte, end_of_input
//   result    empty / pop      out_kind ... length_seconds
//   config    max_seg_size_we  max_seg_size
//
// One input transaction is taken per clock while full is low; the front
// parser finishes each byte in the cycle it is accepted.
// A result goes from the pending queue into the output queue through the
// three-stage divide-by-constant pipeline for the time fields.
// arst_n clears control state, not stored data; max_seg_size returns to 4096.
// full rises only while the pending queue is full because the output is stalled.
module tagged_audio_chunk_deframer
	import tacd_pkg::*;
#(
	parameter int MID_DEPTH = MID_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        max_seg_size_we,
	input  logic [16:0] max_seg_size,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_input,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  out_kind,
	output logic [7:0]  payload_byte,
	output logic        segment_first,
	output logic        segment_last,
	output logic        frame_begin,
	output logic        frame_finish,
	output logic [34:0] presentation_time,
	output logic [17:0] time_seconds,
	output logic [31:0] segment_offset,
	output logic [17:0] length_seconds
);
	logic      in_go, emit, mid_empty, mid_pop;
	mid_item_t front_item, mid_item;
	out_item_t out_item;

	assign in_go = push && !full;

	tacd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(max_seg_size_we),
		.cfg_data(max_seg_size),
		.in_go(in_go),
		.in_byte(data_byte),
		.in_eoi(end_of_input),
		.emit(emit),
		.item(front_item)
	);

	tacd_fifo #(
		.W($bits(mid_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(in_go && emit),
		.wr_data(front_item),
		.full(full),
		.rd_en(mid_pop),
		.rd_data(mid_item),
		.empty(mid_empty),
		.count()
	);

	tacd_back #(
		.OUT_DEPTH(OUT_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mid_item(mid_item),
		.mid_empty(mid_empty),
		.mid_pop(mid_pop),
		.pop(pop),
		.empty(empty),
		.out_item(out_item)
	);

	assign out_kind          = out_item.kind;
	assign payload_byte      = out_item.payload_byte;
	assign segment_first     = out_item.segment_first;
	assign segment_last      = out_item.segment_last;
	assign frame_begin       = out_item.frame_begin;
	assign frame_finish      = out_item.frame_finish;
	assign presentation_time = out_item.presentation_time;
	assign time_seconds      = out_item.time_seconds;
	assign segment_offset    = out_item.segment_offset;
	assign length_seconds    = out_item.length_seconds;
endmodule

@@ rtl/core/tacd_checker.sv @@
// Port-level checks of the tagged audio chunk deframer, bound to the top level.
// Uses tacd_pkg and tagged_audio_chunk_deframer_assert.svh.
`include "tagged_audio_chunk_deframer_assert.svh"
module tacd_checker
	import tacd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  out_kind,
	input logic [7:0]  payload_byte,
	input logic        segment_first,
	input logic [31:0] segment_offset,
	input logic [17:0] length_seconds
);
	`TACD_ASSERT_NOW(a_kind_known, clk, arst_n, !empty, out_kind <= KIND_ERROR)
	`TACD_ASSERT_NOW(a_status_clean, clk, arst_n, !empty && out_kind != KIND_PAYLOAD, payload_byte == 8'd0 && segment_first == 1'b0 && segment_offset == 32'd0)
	`TACD_ASSERT_NOW(a_len_only_hdr, clk, arst_n, !empty && out_kind != KIND_HDR_OK, length_seconds == 18'd0)
	`TACD_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_kind) && $stable(payload_byte))
endmodule

bind tagged_audio_chunk_deframer tacd_checker u_tacd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.out_kind(out_kind),
	.payload_byte(payload_byte),
	.segment_first(segment_first),
	.segment_offset(segment_offset),
	.length_seconds(length_seconds)
);
